### design/mlcg_pkg.sv
`default_nettype none

package mlcg_pkg;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned CodeW   = 8;
  localparam int unsigned GainW   = 12;

  // Companding constants
  localparam logic [15:0]       MuBias    = 16'd132;
  localparam logic [15:0]       MuClip    = 16'd32635;
  localparam logic [GainW-1:0]  GainReset = 12'd256;

  // Saturation limits of the scaled sample
  localparam logic signed [28:0] SatMax = 29'sd32767;
  localparam logic signed [28:0] SatMin = -29'sd32768;

  // Operation selected by each transaction
  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // Compress a signed linear sample into an inverted mu-law byte.
  function automatic logic [CodeW-1:0] mu_encode(logic signed [SampleW-1:0] pcm);
    logic        sign;
    logic [15:0] mag;
    logic [14:0] biased;
    logic [2:0]  expo;
    logic [14:0] shifted;
    sign = pcm[15];
    // Negating the most negative sample gives 0x8000, which is the right magnitude.
    mag  = sign ? 16'(-pcm) : 16'(pcm);
    if (mag > MuClip) begin
      mag = MuClip;
    end
    biased = 15'(mag + MuBias);
    // Priority encoder over bits 14..8: the highest set bit wins.
    expo = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (biased[i+7]) begin
        expo = 3'(i);
      end
    end
    shifted = biased >> (4'(expo) + 4'd3);
    return ~{sign, expo, shifted[3:0]};
  endfunction

  // Expand an inverted mu-law byte back into a linear sample.
  function automatic logic [SampleW-1:0] mu_decode(logic [CodeW-1:0] code);
    logic [7:0]  u;
    logic [15:0] t;
    u = ~code;
    t = 16'({u[3:0], 3'b000}) + MuBias;
    t = t << u[6:4];
    return u[7] ? (MuBias - t) : (t - MuBias);
  endfunction

endpackage

`default_nettype wire

### design/mlcg_in_if.sv
`default_nettype none

interface mlcg_in_if
  import mlcg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  mode_e                      mode;
  logic signed [SampleW-1:0]  sample_in;
  logic [CodeW-1:0]           code_in;

  modport source (output valid, mode, sample_in, code_in, input ready);
  modport sink   (input valid, mode, sample_in, code_in, output ready);
endinterface

`default_nettype wire

### design/mlcg_out_if.sv
`default_nettype none

interface mlcg_out_if
  import mlcg_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic [CodeW-1:0]           code_out;
  logic signed [SampleW-1:0]  sample_out;

  modport source (output valid, code_out, sample_out, input ready);
  modport sink   (input valid, code_out, sample_out, output ready);
endinterface

`default_nettype wire

### design/mlcg_cfg_if.sv
`default_nettype none

interface mlcg_cfg_if
  import mlcg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [GainW-1:0]  mic_gain;

  modport source (output valid, mic_gain, input ready);
  modport sink   (input valid, mic_gain, output ready);
endinterface

`default_nettype wire

### design/mu_law_codec_with_gain.sv
`default_nettype none

// G.711 mu-law codec with a microphone gain on the encode path. Each input
// transaction either encodes sample_in (mode 0: scaled by mic_gain, unsigned
// Q4.8 with 256 as unity, truncated toward zero and saturated to 16 bits) or
// decodes code_in (mode 1), and yields exactly one output transaction; the
// unused output field reads as zero. The block is a two-stage pipeline: an
// input register, then the 16x12 gain multiplier and companding logic feeding
// a result register. The result is offered once it has passed the input register
// and then the result register, and a new transaction is accepted every
// cycle while the output side keeps taking results. mic_gain resets to unity
// and is written through the configuration channel, which is always ready;
// write it only while idle.
module mu_law_codec_with_gain
  import mlcg_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  mlcg_cfg_if.sink     cfg_i,
  mlcg_in_if.sink      in_ch_i,
  mlcg_out_if.source   out_ch_o
);

  logic                       in_valid_q;
  mode_e                      mode_q;
  logic signed [SampleW-1:0]  sample_q;
  logic [CodeW-1:0]           code_q;

  logic                       out_valid_q;
  logic [CodeW-1:0]           code_out_q, code_out_d;
  logic signed [SampleW-1:0]  sample_out_q, sample_out_d;

  logic [GainW-1:0]           gain_q;

  logic                       out_adv;
  logic                       in_adv;

  logic signed [28:0]         product;
  logic signed [28:0]         scaled;
  logic signed [SampleW-1:0]  sat_sample;

  // Gain register, written by any configuration transaction.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_i.valid) begin
      gain_q <= cfg_i.mic_gain;
    end
  end

  // Pipeline flow control: each stage moves when the next one is free or emptying.
  assign out_adv        = !out_valid_q || out_ch_o.ready;
  assign in_adv         = !in_valid_q || out_adv;
  assign in_ch_i.ready  = in_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_ch_i.valid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_adv && in_ch_i.valid) begin
      mode_q   <= in_ch_i.mode;
      sample_q <= in_ch_i.sample_in;
      code_q   <= in_ch_i.code_in;
    end
  end

  // Gain: signed product, divide by 256 rounding toward zero, then saturate.
  always_comb begin
    product = 29'(sample_q) * $signed({17'd0, gain_q});
    scaled  = product >>> 8;
    if (product[28] && (product[7:0] != 8'd0)) begin
      scaled = scaled + 29'sd1;
    end
    if (scaled > SatMax) begin
      sat_sample = SampleW'(SatMax);
    end else if (scaled < SatMin) begin
      sat_sample = SampleW'(SatMin);
    end else begin
      sat_sample = SampleW'(scaled);
    end
  end

  // Companding in the selected direction; the other field is zero.
  always_comb begin
    unique case (mode_q)
      MODE_ENCODE: begin
        code_out_d   = mu_encode(sat_sample);
        sample_out_d = '0;
      end
      MODE_DECODE: begin
        code_out_d   = '0;
        sample_out_d = mu_decode(code_q);
      end
      default: begin
        code_out_d   = '0;
        sample_out_d = '0;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_adv && in_valid_q) begin
      code_out_q   <= code_out_d;
      sample_out_q <= sample_out_d;
    end
  end

  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.code_out   = code_out_q;
  assign out_ch_o.sample_out = sample_out_q;

endmodule

`default_nettype wire

### bench/tb_mu_law_codec_with_gain.sv
`timescale 1ns / 100ps

module tb_mu_law_codec_with_gain;
  import mlcg_pkg::*;

  // Companding and gain constants used by the predictor
  localparam int Bias       = 132;
  localparam int MagClip    = 32635;
  localparam int SatHigh    = 32767;
  localparam int SatLow     = -32768;
  localparam int UnityGain  = 256;
  localparam int MaxGain    = 4095;
  localparam int CycleLimit = 400000;
  localparam int PhaseItems = 130;

  // One expected output transaction
  typedef struct packed {
    logic [CodeW-1:0]          code;
    logic signed [SampleW-1:0] sample;
  } codec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mlcg_cfg_if cfg_ch ();
  mlcg_in_if  in_ch ();
  mlcg_out_if out_ch ();

  mu_law_codec_with_gain dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_ch),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch)
  );

  codec_result_t     pending_results[$];
  logic [GainW-1:0]  gain_setting;
  int unsigned       error_count;
  int unsigned       cycle_count;
  int unsigned       encode_count;
  int unsigned       decode_count;
  int unsigned       gain_writes;
  int unsigned       stall_left;
  bit                sender_steady;
  bit                sink_steady;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scale a sample by the Q4.8 gain, truncate toward zero and saturate.
  function automatic logic signed [SampleW-1:0] apply_mic_gain(
      logic signed [SampleW-1:0] pcm, logic [GainW-1:0] gain);
    longint product;
    longint scaled;
    product = longint'(pcm) * longint'(gain);
    scaled  = product / 256;
    if (scaled > SatHigh) begin
      scaled = SatHigh;
    end
    if (scaled < SatLow) begin
      scaled = SatLow;
    end
    return SampleW'(scaled);
  endfunction

  // Compress a linear sample to an inverted mu-law byte.
  function automatic logic [CodeW-1:0] mu_compress(logic signed [SampleW-1:0] pcm);
    logic neg;
    int   mag;
    int   seg;
    int   mant;
    neg = pcm[SampleW-1];
    mag = neg ? -int'(pcm) : int'(pcm);
    if (mag > MagClip) begin
      mag = MagClip;
    end
    mag = mag + Bias;
    seg = 0;
    for (int b = 8; b <= 14; b++) begin
      if (mag[b]) begin
        seg = b - 7;
      end
    end
    mant = (mag >> (seg + 3)) & 15;
    return ~{neg, seg[2:0], mant[3:0]};
  endfunction

  // Expand an inverted mu-law byte to a linear sample.
  function automatic logic signed [SampleW-1:0] mu_expand(logic [CodeW-1:0] code);
    logic [7:0] inv;
    int         lin;
    inv = ~code;
    lin = ((int'(inv[3:0]) << 3) + Bias) << inv[6:4];
    return inv[7] ? SampleW'(Bias - lin) : SampleW'(lin - Bias);
  endfunction

  // Expected output of one accepted input transaction.
  function automatic codec_result_t predict_codec(mode_e op, logic signed [SampleW-1:0] pcm,
                                                  logic [CodeW-1:0] code);
    codec_result_t res;
    res = '0;
    if (op == MODE_ENCODE) begin
      res.code = mu_compress(apply_mic_gain(pcm, gain_setting));
    end else begin
      res.sample = mu_expand(code);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
             want);
    error_count++;
  endtask

  // Gap length before an item: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  // Offer one item and hold it until the transaction completes.
  task automatic send_item(mode_e op, logic signed [SampleW-1:0] pcm, logic [CodeW-1:0] code);
    int unsigned gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= op;
    in_ch.sample_in <= pcm;
    in_ch.code_in   <= code;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(predict_codec(op, pcm, code));
    if (op == MODE_ENCODE) begin
      encode_count++;
    end else begin
      decode_count++;
    end
  endtask

  task automatic send_encode(logic signed [SampleW-1:0] pcm);
    send_item(MODE_ENCODE, pcm, CodeW'($urandom));
  endtask

  task automatic send_decode(logic [CodeW-1:0] code);
    send_item(MODE_DECODE, SampleW'($urandom), code);
  endtask

  // Stop sending and wait until every result is back and the pipeline is empty.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [GainW-1:0] gain);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.mic_gain <= gain;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    gain_setting = gain;
    gain_writes++;
  endtask

  // A random item: either mode, samples full-range or small to reach low segments.
  task automatic send_random_item();
    logic signed [SampleW-1:0] pcm;
    if ($urandom_range(0, 1) == 1) begin
      send_decode(CodeW'($urandom));
    end else begin
      if ($urandom_range(0, 1) == 1) begin
        pcm = SampleW'($urandom);
      end else begin
        pcm = SampleW'(int'($urandom_range(0, 4095)) - 2048);
      end
      send_encode(pcm);
    end
  endtask

  // Output side stalls: mostly ready, short stalls, occasional long ones.
  always @(posedge clk_i) begin
    int unsigned r;
    r = $urandom_range(0, 99);
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (sink_steady || r < 70) begin
      out_ch.ready <= 1'b1;
    end else if (r < 97) begin
      stall_left = $urandom_range(0, 3);
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = $urandom_range(10, 40);
      out_ch.ready <= 1'b0;
    end
  end

  // Compare every completed output transaction with the oldest expectation.
  always @(posedge clk_i) begin
    codec_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, code_out", 32'(out_ch.code_out), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.code_out !== want.code) begin
          report_mismatch("code_out", 32'(out_ch.code_out), 32'(want.code));
        end
        if (out_ch.sample_out !== want.sample) begin
          report_mismatch("sample_out", 32'(out_ch.sample_out), 32'(want.sample));
        end
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timed out with %0d results outstanding.", pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Extremes of the sample and code at the reset gain, including the most
  // negative sample and magnitudes either side of the clip level.
  task automatic test_unity_extremes();
    send_encode(-16'sd32768);
    send_encode(16'sd32767);
    send_encode(16'sd0);
    send_encode(-16'sd1);
    send_encode(16'sd1);
    send_encode(16'sd32635);
    send_encode(16'sd32636);
    send_encode(-16'sd32635);
    send_encode(16'sd31);
    send_decode(8'h00);
    send_decode(8'hFF);
    send_decode(8'h7F);
    send_decode(8'h80);
    send_decode(8'h0F);
    send_decode(8'hF0);
    wait_idle();
  endtask

  // Zero gain: every sample compresses to silence.
  task automatic test_zero_gain();
    write_gain(GainW'(0));
    send_encode(16'sd32767);
    send_encode(-16'sd32768);
    send_encode(16'sd5);
    wait_idle();
  endtask

  // Largest gain: large products saturate, small ones truncate toward zero.
  task automatic test_gain_overflow();
    write_gain(GainW'(MaxGain));
    send_encode(16'sd32767);
    send_encode(-16'sd32768);
    send_encode(16'sd100);
    send_encode(-16'sd100);
    send_encode(16'sd8);
    send_encode(-16'sd8);
    wait_idle();
  endtask

  // The sender stops until every result has drained, then resumes.
  task automatic test_drain_pause();
    write_gain(GainW'(UnityGain));
    repeat (10) send_random_item();
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (10) send_random_item();
    wait_idle();
  endtask

  // Random traffic over a series of gain settings, some phases without gaps.
  task automatic test_random_stream();
    logic [GainW-1:0] gains[8];
    gains[0] = GainW'(UnityGain);
    gains[1] = GainW'(MaxGain);
    gains[2] = GainW'(0);
    gains[3] = GainW'(1);
    gains[4] = GainW'($urandom_range(0, MaxGain));
    gains[5] = GainW'(2048);
    gains[6] = GainW'($urandom_range(0, 511));
    gains[7] = GainW'($urandom_range(0, MaxGain));
    for (int p = 0; p < 8; p++) begin
      write_gain(gains[p]);
      sender_steady = (p % 3 == 1);
      sink_steady   = (p % 4 == 2);
      repeat (PhaseItems - 2) send_random_item();
      sender_steady = 1'b0;
      sink_steady   = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.mic_gain = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_ENCODE;
    in_ch.sample_in = '0;
    in_ch.code_in   = '0;
    out_ch.ready    = 1'b0;
    gain_setting    = GainW'(UnityGain);
    error_count     = 0;
    cycle_count     = 0;
    encode_count    = 0;
    decode_count    = 0;
    gain_writes     = 0;
    stall_left      = 0;
    sender_steady   = 1'b0;
    sink_steady     = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unity_extremes();
    test_zero_gain();
    test_gain_overflow();
    test_drain_pause();
    test_random_stream();

    $display("Checked %0d encode and %0d decode transactions over %0d gain writes.",
             encode_count, decode_count, gain_writes);
    $display("Gains ranged from zero to full scale, with saturation and clip cases.");
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
